// File: rtl/core/txdma_pkg.sv
`default_nettype none

package txdma_pkg;

   // Ring geometry; pointer arithmetic assumes a power-of-two depth
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   // Fixed field widths of the request and response transactions
   localparam int CMD_W   = 2;
   localparam int DATA_W  = 8;
   localparam int FIELD_W = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 2'd0,
      CMD_FETCH   = 2'd1,
      CMD_DONE    = 2'd2,
      CMD_REFUSED = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/txdma_ram.sv
`default_nettype none

module txdma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/tx_ring_dma_chunker.sv
`default_nettype none

// Transmit ring with DMA chunk launch. Each request transaction (push, fetch,
// transfer complete, launch refused) gives exactly one response transaction.
// One transaction is taken every cycle: the pointer and in-flight updates are
// a few additions done in the cycle of acceptance, and the response sits in a
// single output register, so req_stall is only asserted while a response is
// held by rsp_stall. Fetch data comes from the registered read port of the
// ring memory and appears together with the response. A fetch of a ring
// entry never pushed returns an undefined byte. No clearing pass is needed
// after reset.
module tx_ring_dma_chunker
   import txdma_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [DATA_W-1:0]  req_data_byte,
   input  wire logic               req_last_byte,
   input  wire logic [FIELD_W-1:0] req_fetch_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_accepted,
   output logic                    rsp_launch_valid,
   output logic      [FIELD_W-1:0] rsp_launch_start,
   output logic      [FIELD_W-1:0] rsp_launch_length,
   output logic      [DATA_W-1:0]  rsp_read_data,
   output logic      [FIELD_W-1:0] rsp_free_space
);

   localparam logic [PTR_W:0] DEPTH_W = (PTR_W+1)'(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

   // Control state
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] in_flight_ff, in_flight_in;

   // Response payload
   logic             accepted_ff, accepted_in;
   logic             launch_valid_ff, launch_valid_in;
   logic [PTR_W-1:0] launch_start_ff, launch_start_in;
   logic [PTR_W-1:0] launch_length_ff, launch_length_in;
   logic [PTR_W-1:0] free_space_ff, free_space_in;
   logic             fetch_ff, fetch_in;

   logic              take;
   cmd_type           cmd;
   logic [PTR_W-1:0]  held_cur;
   logic [PTR_W-1:0]  held_new;
   logic              push_ok;
   logic              attempt;
   logic [PTR_W-1:0]  flight_mid;
   logic [PTR_W:0]    rd_sum;
   logic [PTR_W:0]    to_end;
   logic              launch;
   logic [DATA_W-1:0] ram_rd_data;

   function automatic logic [PTR_W-1:0] held_of(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] rp);
      logic [PTR_W:0] diff;
      diff = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp}) : ({1'b0, wp} + DEPTH_W - {1'b0, rp});
      return diff[PTR_W-1:0];
   endfunction

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign cmd       = cmd_type'(req_cmd);
   assign held_cur  = held_of(wr_ptr_ff, rd_ptr_ff);

   // Decode the transaction and advance pointers
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      flight_mid = in_flight_ff;
      push_ok    = 1'b0;
      attempt    = 1'b0;
      fetch_in   = 1'b0;
      rd_sum     = {1'b0, rd_ptr_ff} + {1'b0, in_flight_ff};
      unique case (cmd)
         CMD_PUSH: begin
            push_ok   = (held_cur != LAST_PTR);
            wr_ptr_in = push_ok ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1)
                                : wr_ptr_ff;
            attempt   = req_last_byte;
         end
         CMD_FETCH: begin
            fetch_in = 1'b1;
         end
         CMD_DONE: begin
            rd_ptr_in  = (rd_sum >= DEPTH_W) ? PTR_W'(rd_sum - DEPTH_W) : rd_sum[PTR_W-1:0];
            flight_mid = '0;
            attempt    = 1'b1;
         end
         CMD_REFUSED: begin
            flight_mid = '0;
         end
         default: begin
            flight_mid = in_flight_ff;
         end
      endcase
   end

   // Launch a chunk up to the write pointer or the ring end, whichever is nearer
   always_comb begin
      held_new         = held_of(wr_ptr_in, rd_ptr_in);
      to_end           = DEPTH_W - {1'b0, rd_ptr_in};
      launch           = attempt & (flight_mid == '0) & (held_new != '0);
      launch_valid_in  = launch;
      launch_start_in  = launch ? rd_ptr_in : '0;
      launch_length_in = '0;
      if (launch) begin
         launch_length_in = ({1'b0, held_new} < to_end) ? held_new : to_end[PTR_W-1:0];
      end
      in_flight_in  = launch ? launch_length_in : flight_mid;
      accepted_in   = push_ok;
      free_space_in = LAST_PTR - held_new;
      rsp_valid_in  = take ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   // Hold state and response until the next accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         in_flight_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            wr_ptr_ff    <= wr_ptr_in;
            rd_ptr_ff    <= rd_ptr_in;
            in_flight_ff <= in_flight_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff      <= accepted_in;
         launch_valid_ff  <= launch_valid_in;
         launch_start_ff  <= launch_start_in;
         launch_length_ff <= launch_length_in;
         free_space_ff    <= free_space_in;
         fetch_ff         <= fetch_in;
      end
   end

   // Ring storage; read only on fetch so the byte holds through a stall
   txdma_ram #(
      .WIDTH(DATA_W),
      .DEPTH(RING_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (take & push_ok),
      .wr_addr(wr_ptr_ff),
      .wr_data(req_data_byte),
      .rd_en  (take & fetch_in),
      .rd_addr(req_fetch_index[PTR_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_launch_valid  = launch_valid_ff;
   assign rsp_launch_start  = FIELD_W'(launch_start_ff);
   assign rsp_launch_length = FIELD_W'(launch_length_ff);
   assign rsp_free_space    = FIELD_W'(free_space_ff);
   assign rsp_read_data     = fetch_ff ? ram_rd_data : '0;

   // In-flight bytes never exceed what the ring holds
   a_flight_bounded: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= held_cur)
      else $error("in-flight count exceeds held bytes");

   // A launched chunk is never empty and never crosses the ring end
   a_launch_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && launch_valid_ff |->
         launch_length_ff != '0 &&
         ({1'b0, launch_start_ff} + {1'b0, launch_length_ff}) <= DEPTH_W)
      else $error("bad launch chunk");

   // A launch leaves exactly that chunk in flight
   a_launch_flight: assert property (@(posedge clock) disable iff (reset)
      take && launch |=> in_flight_ff == launch_length_ff)
      else $error("in-flight count does not match launch");

endmodule

`default_nettype wire
